@@ rtl/lbt_pkg.sv @@
package lbt_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int STORE_DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = 6;
    localparam int COEF_W      = 32;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_COORD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAPACITY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_BUILD_WR,
        ST_LOOK,
        ST_RESP
    } lbt_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [COEF_W-1:0] wr_data;
    } lbt_store_req_t;

    // start of a row in the packed triangle: row*(row+1)/2
    function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] row);
        logic [2*ROW_W:0] prod;
        prod = {{(ROW_W+1){1'b0}}, row} * {{ROW_W{1'b0}}, row + {{(ROW_W-1){1'b0}}, 1'b1}};
        return ADDR_W'(prod >> 1);
    endfunction

endpackage

@@ rtl/lbt_query_if.sv @@
interface lbt_query_if;
    import lbt_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_index;
    logic [ROW_W-1:0] column_index;

    modport source (output valid, output row_index, output column_index, input ready);
    modport sink   (input valid, input row_index, input column_index, output ready);
endinterface

@@ rtl/lbt_result_if.sv @@
interface lbt_result_if;
    import lbt_pkg::*;

    logic                valid;
    logic                ready;
    logic [COEF_W-1:0]   coefficient;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output coefficient, output status, input ready);
    modport sink   (input valid, input coefficient, input status, output ready);
endinterface

@@ rtl/lbt_store.sv @@
module lbt_store (
    input  logic                          clk,
    input  lbt_pkg::lbt_store_req_t       req,
    output logic [lbt_pkg::COEF_W-1:0]    rd_data
);
    import lbt_pkg::*;

    logic [COEF_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule

@@ rtl/lbt_seq.sv @@
module lbt_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  logic [lbt_pkg::ROW_W-1:0]      q_row,
    input  logic [lbt_pkg::ROW_W-1:0]      q_col,
    output logic                           r_valid,
    input  logic                           r_ready,
    output logic [lbt_pkg::COEF_W-1:0]     r_coef,
    output logic [lbt_pkg::STATUS_W-1:0]   r_status,
    output lbt_pkg::lbt_store_req_t        req,
    input  logic [lbt_pkg::COEF_W-1:0]     rd_data
);
    import lbt_pkg::*;

    lbt_state_t          state_reg, state_next;
    logic [ROW_W-1:0]    rows_built_reg, rows_built_next;
    logic [ADDR_W-1:0]   build_base_reg, build_base_next;
    logic [ROW_W-1:0]    col_reg, col_next;
    logic [COEF_W-1:0]   left_reg, left_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ROW_W-1:0]    qcol_reg, qcol_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   prev_base;

    assign prev_base = build_base_reg - ADDR_W'(rows_built_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rows_built_reg <= '0;
            build_base_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rows_built_reg <= rows_built_next;
            build_base_reg <= build_base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        left_reg   <= left_next;
        row_reg    <= row_next;
        qcol_reg   <= qcol_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        rows_built_next = rows_built_reg;
        build_base_next = build_base_reg;
        col_next        = col_reg;
        left_next       = left_reg;
        row_next        = row_reg;
        qcol_next       = qcol_reg;
        status_next     = status_reg;
        q_ready         = 1'b0;
        r_valid         = 1'b0;
        req             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    row_next  = q_row;
                    qcol_next = q_col;
                    col_next  = '0;
                    left_next = COEF_W'(1);
                    if (q_col > q_row)
                    begin
                        status_next = STATUS_BAD_COORD;
                        state_next  = ST_RESP;
                    end
                    else if (q_row >= ROW_W'(MAX_ROWS))
                    begin
                        status_next = STATUS_CAPACITY;
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        state_next  = (q_row >= rows_built_reg) ? ST_BUILD : ST_LOOK;
                    end
                end
            end
            ST_BUILD:
            begin
                if (col_reg == '0 || col_reg == rows_built_reg)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = build_base_reg + ADDR_W'(col_reg);
                    req.wr_data = COEF_W'(1);
                    left_next   = COEF_W'(1);
                    if (col_reg == rows_built_reg)
                    begin
                        rows_built_next = rows_built_reg + ROW_W'(1);
                        build_base_next = build_base_reg + ADDR_W'(rows_built_reg)
                                        + ADDR_W'(1);
                        col_next        = '0;
                        state_next      = (rows_built_reg == row_reg) ? ST_LOOK : ST_BUILD;
                    end
                    else
                    begin
                        col_next = col_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = prev_base + ADDR_W'(col_reg);
                    state_next  = ST_BUILD_WR;
                end
            end
            ST_BUILD_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = build_base_reg + ADDR_W'(col_reg);
                req.wr_data = left_reg + rd_data;
                left_next   = rd_data;
                col_next    = col_reg + ROW_W'(1);
                state_next  = ST_BUILD;
            end
            ST_LOOK:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = row_base(row_reg) + ADDR_W'(qcol_reg);
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                r_valid = 1'b1;
                if (r_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign r_status = status_reg;
    assign r_coef   = (status_reg == STATUS_OK) ? rd_data : '0;
endmodule

@@ rtl/lazy_binomial_table_lookup_top.sv @@
// Lookup of a built row: ST_LOOK reads the store, then ST_RESP hands the result to the output register.
// Building row r writes its end entries as 1 and each inner entry as the sum of two entries
// of row r-1; rows are built once, in order. Bad column or capacity status skips the store read.
// One query at a time: the next query is taken only after the finished result has moved
// into the output register, which stalls while it holds a beat not yet taken.
// Reset clears the built-row count; store contents are undefined and never read unbuilt.
module lazy_binomial_table_lookup_top (
    input logic          clk,
    input logic          rst_n,
    lbt_query_if.sink    query,
    lbt_result_if.source result
);
    import lbt_pkg::*;

    lbt_store_req_t      req;
    logic [COEF_W-1:0]   rd_data;
    logic                r_valid;
    logic                r_ready;
    logic [COEF_W-1:0]   r_coef;
    logic [STATUS_W-1:0] r_status;
    logic                out_valid_reg;
    logic [COEF_W-1:0]   out_coef_reg;
    logic [STATUS_W-1:0] out_status_reg;

    lbt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (query.valid),
        .q_ready  (query.ready),
        .q_row    (query.row_index),
        .q_col    (query.column_index),
        .r_valid  (r_valid),
        .r_ready  (r_ready),
        .r_coef   (r_coef),
        .r_status (r_status),
        .req      (req),
        .rd_data  (rd_data)
    );

    lbt_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // output register: holds one beat until taken
    assign r_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (r_ready)
        begin
            out_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_ready && r_valid)
        begin
            out_coef_reg   <= r_coef;
            out_status_reg <= r_status;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.coefficient = out_coef_reg;
    assign result.status      = out_status_reg;
endmodule
